@@ rtl/masked_byte_pattern_scanner_top_macros.svh @@
// assertion helpers for the pattern scanner checker
`ifndef MASKED_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_TOP_MACROS_SVH

// clocked property, quiet while reset is applied
`define MBPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that also runs through reset
`define MBPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// shared widths, action codes and register indexes of the pattern scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

    localparam int ACTION_W     = 2;
    localparam int BYTE_W       = 8;
    localparam int PAT_INDEX_W  = 8;
    localparam int ADDR_W       = 64;
    localparam int COUNT_W      = 16;
    localparam int LEN_CFG_W    = 9;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 64;

    // item actions
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MATCH_ONLY = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADDRESS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_ADDRESS      = 8'd3;

    localparam logic [LEN_CFG_W-1:0] PATTERN_LENGTH_RESET = 9'd1;
    localparam logic [ADDR_W-1:0]    END_ADDRESS_RESET    = {ADDR_W{1'b1}};

endpackage

`default_nettype wire

@@ rtl/mbps_if.sv @@
// ----------------------------------------------------------------------------
// mbps_if
// valid/ready channels for scanner items and match results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mbps_item_if import mbps_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [PAT_INDEX_W-1:0] pattern_index;
    logic [BYTE_W-1:0]      pattern_byte;
    logic                   care;
    logic [BYTE_W-1:0]      data_byte;

    modport source (output valid, action, pattern_index, pattern_byte, care, data_byte,
                    input ready);
    modport sink   (input valid, action, pattern_index, pattern_byte, care, data_byte,
                    output ready);
endinterface

interface mbps_result_if import mbps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  match_address;
    logic [COUNT_W-1:0] match_number;

    modport source (output valid, match_address, match_number, input ready);
    modport sink   (input valid, match_address, match_number, output ready);
endinterface

`default_nettype wire

@@ rtl/masked_byte_pattern_scanner_top.sv @@
// Masked byte pattern scanner. Takes one item per cycle when not stalled and
// reports matches via the input and result registers. An item is registered
// with its scan address (start address plus byte position, one 64-bit add),
// then the byte is compared against every pattern position at once and the
// partial-match vector shifts; a full match loads the result register. A
// waiting result stalls the pipe only while it is not taken. Pattern and
// care bits live in flip-flops, one per position, and are not cleared by reset.
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// wildcard byte pattern search over a byte stream with match address and count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_scanner_top import mbps_pkg::*; #(
    parameter int MAX_PATTERN = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    mbps_item_if.sink              item,
    mbps_result_if.source          result
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW    = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
    localparam int IW    = (IDX_W > PAT_INDEX_W) ? IDX_W : PAT_INDEX_W;

    // configuration
    logic [LEN_CFG_W-1:0] len_cfg_reg;
    logic                 first_reg;
    logic [ADDR_W-1:0]    start_reg;
    logic [ADDR_W-1:0]    end_reg;

    // input stage
    logic                   s1_valid_reg;
    logic [ACTION_W-1:0]    s1_action_reg;
    logic [PAT_INDEX_W-1:0] s1_index_reg;
    logic [BYTE_W-1:0]      s1_pbyte_reg;
    logic                   s1_care_reg;
    logic [BYTE_W-1:0]      s1_data_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic [ADDR_W-1:0]      pos_reg;

    // scan state
    logic [BYTE_W-1:0]      pattern_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care_reg;
    logic [MAX_PATTERN-1:0] partial_reg;
    logic [MAX_PATTERN-1:0] partial_next;
    logic                   found_reg;
    logic                   found_next;
    logic [COUNT_W-1:0]     total_reg;
    logic [COUNT_W-1:0]     total_next;

    // result register
    logic               res_valid_reg;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [COUNT_W-1:0] res_number_reg;

    logic                   advance;
    logic                   accept;
    logic                   exec;
    logic                   report;
    logic [CW-1:0]          len_eff;
    logic [IDX_W-1:0]       last_idx;
    logic [IW-1:0]          ld_idx;
    logic [MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN-1:0] partial_scan;
    logic                   in_range;
    logic                   hit;
    logic [COUNT_W-1:0]     total_inc;

    assign advance     = !res_valid_reg || result.ready;
    assign item.ready  = !s1_valid_reg || advance;
    assign accept      = item.valid && item.ready;
    assign exec        = s1_valid_reg && advance;

    assign result.valid         = res_valid_reg;
    assign result.match_address = res_addr_reg;
    assign result.match_number  = res_number_reg;

    // length in use: zero counts as one, clipped to the pattern depth
    always_comb
    begin
        len_eff = CW'(len_cfg_reg);
        if (len_eff == '0)
            len_eff = CW'(1);
        if (len_eff > CW'(MAX_PATTERN))
            len_eff = CW'(MAX_PATTERN);
    end

    assign last_idx = IDX_W'(len_eff - CW'(1));
    assign ld_idx   = IW'(s1_index_reg);
    assign in_range = s1_addr_reg < end_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            eq[i] = !care_reg[i] || (pattern_reg[i] == s1_data_reg);
        end
        partial_scan[0] = eq[0];
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            partial_scan[i] = partial_reg[i-1] && eq[i];
        end
        // positions beyond the length in use stay clear
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (CW'(i) >= len_eff)
                partial_scan[i] = 1'b0;
        end
    end

    assign hit       = partial_scan[last_idx];
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + COUNT_W'(1);

    always_comb
    begin
        partial_next = partial_reg;
        found_next   = found_reg;
        total_next   = total_reg;
        report       = 1'b0;
        if (exec)
        begin
            unique case (s1_action_reg)
                ACT_START:
                begin
                    partial_next = '0;
                    found_next   = 1'b0;
                    total_next   = '0;
                end
                ACT_SCAN:
                begin
                    if (!in_range)
                        partial_next = '0;
                    else
                    begin
                        partial_next = partial_scan;
                        if (hit && !(first_reg && found_reg))
                        begin
                            report     = 1'b1;
                            found_next = 1'b1;
                            total_next = total_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg   <= PATTERN_LENGTH_RESET;
            first_reg     <= 1'b0;
            start_reg     <= '0;
            end_reg       <= END_ADDRESS_RESET;
            s1_valid_reg  <= 1'b0;
            pos_reg       <= '0;
            partial_reg   <= '0;
            found_reg     <= 1'b0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_PATTERN_LENGTH:   len_cfg_reg <= cfg_data[LEN_CFG_W-1:0];
                    REG_FIRST_MATCH_ONLY: first_reg   <= cfg_data[0];
                    REG_START_ADDRESS:    start_reg   <= cfg_data;
                    REG_END_ADDRESS:      end_reg     <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (accept && item.action == ACT_START)
                pos_reg <= '0;
            else if (accept && item.action == ACT_SCAN)
                pos_reg <= pos_reg + ADDR_W'(1);

            partial_reg <= partial_next;
            found_reg   <= found_next;
            total_reg   <= total_next;

            if (exec)
                res_valid_reg <= report;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= item.action;
            s1_index_reg  <= item.pattern_index;
            s1_pbyte_reg  <= item.pattern_byte;
            s1_care_reg   <= item.care;
            s1_data_reg   <= item.data_byte;
            s1_addr_reg   <= start_reg + pos_reg;
        end
        if (report)
        begin
            res_addr_reg   <= s1_addr_reg - ADDR_W'(last_idx);
            res_number_reg <= total_inc;
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (exec && s1_action_reg == ACT_LOAD && ld_idx == IW'(i))
            begin
                pattern_reg[i] <= s1_pbyte_reg;
                care_reg[i]    <= s1_care_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/mbps_checker.sv @@
// ----------------------------------------------------------------------------
// mbps_checker
// port-level checks of the pattern scanner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "masked_byte_pattern_scanner_top_macros.svh"

module mbps_checker import mbps_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic [ACTION_W-1:0] item_action,
    input logic                result_valid,
    input logic                result_ready,
    input logic [ADDR_W-1:0]   result_match_address,
    input logic [COUNT_W-1:0]  result_match_number
);

    // nothing can come out right after reset
    `MBPS_ASSERT_RST(a_quiet_after_reset, !rst_n |=> !result_valid, "result right after reset")

    // a fresh result comes from a scan item accepted earlier through the input stage
    `MBPS_ASSERT(a_result_from_scan,
        $rose(result_valid) |-> $past(item_valid && item_ready && item_action == ACT_SCAN, 2),
        "result without a scan item two cycles before")

    // a reported match always counts at least itself
    `MBPS_ASSERT(a_count_nonzero, result_valid |-> result_match_number != '0,
        "match reported with zero count")

    // a stalled result holds
    `MBPS_ASSERT(a_result_hold,
        result_valid && !result_ready |=> result_valid && $stable(result_match_address)
            && $stable(result_match_number),
        "stalled result changed")

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_valid           (item.valid),
    .item_ready           (item.ready),
    .item_action          (item.action),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_match_address (result.match_address),
    .result_match_number  (result.match_number)
);

`default_nettype wire
